// File: rtl/spfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfa_pkg: shared types and constants of the segment frame allocator
// Frame table geometry, field widths, word layouts, the frame entry record
// and the controller state encoding.
// ----------------------------------------------------------------------------
package spfa_pkg;

	// Frame table geometry. PAGE_UNITS must be a power of two.
	localparam int FRAMES     = 128;
	localparam int PAGE_UNITS = 16;
	localparam int ID_BITS    = 8;

	// Field widths fixed by the interface.
	localparam int SEG_ID_W   = 8;
	localparam int SIZE_W     = 12;
	localparam int FREE_OUT_W = 8;

	// Derived widths.
	localparam int IDX_W      = $clog2(FRAMES);
	localparam int CNT_W      = $clog2(FRAMES + 1);
	localparam int PAGE_SHIFT = $clog2(PAGE_UNITS);
	localparam int PAGE_W     = SIZE_W + 1 - PAGE_SHIFT;
	localparam int TOTAL_W    = PAGE_W + 2;
	localparam int CMP_W      = (TOTAL_W > CNT_W) ? TOTAL_W : CNT_W;

	// Input word layout, lowest bit first: seg_id, text_size, heap_size, stack_size.
	localparam int SEG_ID_LO = 0;
	localparam int TEXT_LO   = SEG_ID_LO + SEG_ID_W;
	localparam int HEAP_LO   = TEXT_LO + SIZE_W;
	localparam int STACK_LO  = HEAP_LO + SIZE_W;
	localparam int S_FIELD_W = STACK_LO + SIZE_W;
	localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;

	// Output word layout, lowest bit first: ok, frames_free.
	localparam int M_FIELD_W = 1 + FREE_OUT_W;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

	// Request kinds carried on s_tuser.
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		PART_FREE  = 2'd0,
		PART_TEXT  = 2'd1,
		PART_HEAP  = 2'd2,
		PART_STACK = 2'd3
	} part_t;

	typedef struct packed {
		logic               used;
		logic [ID_BITS-1:0] owner;
		part_t              part;
	} frame_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_FINISH = 2'd2
	} state_t;

endpackage

// File: rtl/segment_page_frame_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_page_frame_allocator_core: paged segment frame allocator
// A table of page frames kept in a rotating ring of frame cells, edited by a
// sequencer at the ring head.
// ----------------------------------------------------------------------------
// The allocator owns a table of FRAMES page frames, each free or owned by a
// segment id and tagged text, heap or stack. An allocate word (s_tuser = 0)
// rounds its three sizes up to whole pages and, if enough frames are free,
// claims the lowest free frames in order: text, then heap, then stack. A
// request of zero pages, or one larger than the free count, fails and leaves
// the table alone. A free word (s_tuser = 1) releases every frame of the id
// and reports whether any was found. Each request yields one result word
// with the ok flag and the free frame count after the request. The frame
// table is a ring of FRAMES cells that rotates one place per clock during a
// scan of the table; the sequencer edits each record as it passes the
// ring head. A request that reaches the table has its result loaded in a
// closing cycle after one full turn of the ring, and the next word can be
// accepted once the sequencer is back in idle. A rejected allocation skips
// the ring and goes straight to the closing cycle. One request is in work
// at a time; a finished result sits in an output register, so the next
// word is taken while the previous result still waits for m_tready. The
// closing cycle of a request stretches for as long as that register is
// still full and m_tready stays low. Reset clears every frame at once; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module segment_page_frame_allocator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Bits from the lowest: seg_id[7:0], text_size[19:8], heap_size[31:20],
	// stack_size[43:32], zero fill up to 48 bits.
	input  logic [spfa_pkg::S_TDATA_W-1:0] s_tdata,
	// Bit 0: mode, 0 allocate and 1 free.
	input  logic                           s_tuser,
	// Result channel.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Bits from the lowest: ok[0], frames_free[8:1], zero fill up to 16 bits.
	output logic [spfa_pkg::M_TDATA_W-1:0] m_tdata
);
	import spfa_pkg::*;

	// ring[0] is the head the sequencer looks at; its edited copy re-enters
	// at the far end, so after one full turn the table is back in order.
	frame_t ring [FRAMES];
	frame_t tail;
	logic   shift;

	spfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.head     (ring[0]),
		.tail     (tail),
		.shift    (shift)
	);

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		if (i == FRAMES - 1) begin : g_last
			spfa_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (tail),
				.q      (ring[i])
			);
		end else begin : g_mid
			spfa_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (ring[i+1]),
				.q      (ring[i])
			);
		end
	end

endmodule

// File: rtl/spfa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfa_cell: one frame entry of the rotating frame table
// Holds one frame record and takes its neighbor's record while shifting.
// ----------------------------------------------------------------------------
module spfa_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  spfa_pkg::frame_t d,
	output spfa_pkg::frame_t q
);
	import spfa_pkg::*;

	frame_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= frame_t'('0);
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

// File: rtl/spfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfa_ctrl: request sequencer at the head of the frame ring
// Decodes requests, edits each frame record as it passes the ring head,
// keeps the free frame count and holds the result word.
// ----------------------------------------------------------------------------
module spfa_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [spfa_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [spfa_pkg::M_TDATA_W-1:0]   m_tdata,
	input  spfa_pkg::frame_t                 head,
	output spfa_pkg::frame_t                 tail,
	output logic                             shift
);
	import spfa_pkg::*;

	function automatic logic [PAGE_W-1:0] pages_of(logic [SIZE_W-1:0] size);
		logic [SIZE_W:0] rounded;
		rounded = {1'b0, size} + (SIZE_W + 1)'(PAGE_UNITS - 1);
		return PAGE_W'(rounded >> PAGE_SHIFT);
	endfunction

	state_t state_q, state_d;

	logic                  mode_q;
	logic [ID_BITS-1:0]    id_q;
	logic [PAGE_W-1:0]     rem_text_q, rem_heap_q, rem_stack_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [CNT_W-1:0]      released_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  ok_q;
	logic [CNT_W-1:0]      free_count_q;
	logic                  out_valid_q;
	logic                  out_ok_q;
	logic [FREE_OUT_W-1:0] out_free_q;

	logic                  accept;
	logic [PAGE_W-1:0]     text_pg, heap_pg, stack_pg;
	logic [TOTAL_W-1:0]    total;
	logic                  fits;
	logic                  claim, release_hit, last_frame, load_out;
	logic                  ok_fin;
	logic [CNT_W-1:0]      free_next;

	// Request decode.
	assign accept   = s_tvalid && s_tready;
	assign text_pg  = pages_of(s_tdata[TEXT_LO +: SIZE_W]);
	assign heap_pg  = pages_of(s_tdata[HEAP_LO +: SIZE_W]);
	assign stack_pg = pages_of(s_tdata[STACK_LO +: SIZE_W]);
	assign total    = TOTAL_W'(text_pg) + TOTAL_W'(heap_pg) + TOTAL_W'(stack_pg);
	assign fits     = (total != '0) && (CMP_W'(total) <= CMP_W'(free_count_q));

	// Head edit: claim a free frame while pages remain, or release a match.
	assign claim = (mode_q == MODE_ALLOC) && !head.used &&
		((rem_text_q != '0) || (rem_heap_q != '0) || (rem_stack_q != '0));
	assign release_hit = (mode_q == MODE_FREE) && head.used && (head.owner == id_q);
	assign last_frame  = (idx_q == IDX_W'(FRAMES - 1));

	always_comb begin
		tail = head;
		if (claim) begin
			tail.used  = 1'b1;
			tail.owner = id_q;
			if (rem_text_q != '0) begin
				tail.part = PART_TEXT;
			end else if (rem_heap_q != '0) begin
				tail.part = PART_HEAP;
			end else begin
				tail.part = PART_STACK;
			end
		end else if (release_hit) begin
			tail = frame_t'('0);
		end
	end

	// Result of a finished request.
	assign ok_fin = (mode_q == MODE_ALLOC) ? ok_q : (released_q != '0);
	always_comb begin
		if (mode_q == MODE_ALLOC) begin
			free_next = ok_q ? (free_count_q - CNT_W'(total_q)) : free_count_q;
		end else begin
			free_next = free_count_q + released_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		shift    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if ((s_tuser == MODE_ALLOC) && !fits) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				shift = 1'b1;
				if (last_frame) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Request context and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_ALLOC;
			id_q         <= '0;
			rem_text_q   <= '0;
			rem_heap_q   <= '0;
			rem_stack_q  <= '0;
			total_q      <= '0;
			released_q   <= '0;
			idx_q        <= '0;
			ok_q         <= 1'b0;
			free_count_q <= CNT_W'(FRAMES);
		end else begin
			if (accept) begin
				mode_q      <= s_tuser;
				id_q        <= ID_BITS'(s_tdata[SEG_ID_LO +: SEG_ID_W]);
				rem_text_q  <= text_pg;
				rem_heap_q  <= heap_pg;
				rem_stack_q <= stack_pg;
				total_q     <= total;
				released_q  <= '0;
				idx_q       <= '0;
				ok_q        <= fits;
			end
			if (shift) begin
				idx_q <= idx_q + 1'b1;
				if (claim) begin
					if (rem_text_q != '0) begin
						rem_text_q <= rem_text_q - 1'b1;
					end else if (rem_heap_q != '0) begin
						rem_heap_q <= rem_heap_q - 1'b1;
					end else begin
						rem_stack_q <= rem_stack_q - 1'b1;
					end
				end
				if (release_hit) begin
					released_q <= released_q + 1'b1;
				end
			end
			if (load_out) begin
				free_count_q <= free_next;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ok_q   <= ok_fin;
			out_free_q <= FREE_OUT_W'(free_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({out_free_q, out_ok_q});

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= CNT_W'(FRAMES))
		else $error("free frame count exceeds the table size");

	a_alloc_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && mode_q == MODE_ALLOC && ok_q) |->
		(rem_text_q == '0 && rem_heap_q == '0 && rem_stack_q == '0))
		else $error("allocation finished with pages left unclaimed");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("request accepted without starting work");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && last_frame) |=> (state_q == ST_FINISH && idx_q == '0))
		else $error("scan did not close after one full turn of the ring");

endmodule
